// ===== hdl/otsu_pkg.sv =====
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared types and constants for the Otsu threshold binarizer.
// ----------------------------------------------------------------------------
package otsu_pkg;

	localparam int BINS  = 256;
	localparam int PIX_W = 8;
	localparam int DIG_W = 32;	// digit width of the shared multiplier

	localparam logic [PIX_W-1:0] DEFAULT_THRESHOLD = 8'd128;
	localparam logic [PIX_W-1:0] LAST_BIN          = 8'd255;

	localparam logic FUNC_HIST = 1'b0;
	localparam logic FUNC_BIN  = 1'b1;

	localparam logic KIND_THRESHOLD = 1'b0;
	localparam logic KIND_PIXEL     = 1'b1;

	typedef struct packed {
		logic             func;
		logic [PIX_W-1:0] pixel;
		logic             last;
	} sample_t;

	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] threshold;
		logic             white;
		logic             overflow;
	} result_t;

endpackage

// ===== hdl/otsu_ram.sv =====
// ----------------------------------------------------------------------------
// otsu_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module otsu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/otsu_threshold_binarizer_core.sv =====
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer_core
// Two-pass Otsu binarizer: builds a 256-bin histogram, searches the threshold
// of greatest between-class variance with exact integer compares on one
// shared 32x32 multiplier, then binarizes replayed pixels.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload  | handshake
//  --------+-----+----------+------------------------------
//  sample  | in  | sample_t | sample_valid / sample_stall
//  result  | out | result_t | result_valid / result_stall
//
// Binarize item: result registered on acceptance. Histogram item: read-modify-write
// of the bin RAM through S_INC, no RAM access when the frame is already full.
// Last pixel: search over 256 bins; a bin that leaves a class empty only reads
// and clears its word, else up to six products run on the shared multiplier, each in
// XDIG*YDIG digit steps then S_DRAIN and S_WB (XDIG*YDIG = 6 at 160x120).
// After reset a pass over all 256 bins zeroes the bin RAM; sample_stall stays high.
// sample_stall is high while an item is in progress or a held result is stalled.
// ----------------------------------------------------------------------------
module otsu_threshold_binarizer_core
	import otsu_pkg::*;
#(
	parameter int IMG_WIDTH  = 160,
	parameter int IMG_HEIGHT = 120
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int MAXP   = IMG_WIDTH * IMG_HEIGHT;
	localparam int CNT_W  = $clog2(MAXP + 1);
	localparam int SUM_W  = CNT_W + PIX_W;
	localparam int PROD_W = SUM_W + CNT_W;
	localparam int N_W    = 2 * PROD_W;
	localparam int D_W    = 2 * CNT_W;
	localparam int XDIG   = (N_W + DIG_W - 1) / DIG_W;
	localparam int YDIG   = (PROD_W + DIG_W - 1) / DIG_W;
	localparam int XW     = XDIG * DIG_W;
	localparam int YW     = YDIG * DIG_W;
	localparam int ACC_W  = XW + YW;
	localparam int IW     = (XDIG > 1) ? $clog2(XDIG) : 1;
	localparam int JW     = (YDIG > 1) ? $clog2(YDIG) : 1;
	localparam int SH_W   = $clog2(XDIG + YDIG);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_INC, S_SRD, S_SACC, S_MUL, S_DRAIN, S_WB, S_DONE
	} state_t;

	// products of one candidate: a = s0*T, b = S*c0, d = c0*c1, n = |a-b|^2,
	// lhs = n*best_d, rhs = best_n*d
	typedef enum logic [2:0] {
		OP_A, OP_B, OP_D, OP_N, OP_L, OP_R
	} op_t;

	state_t              state_q;
	op_t                 op_q;
	logic [PIX_W-1:0]    t_q;
	logic [PIX_W-1:0]    pix_q;
	logic                last_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SUM_W-1:0]    sum_q;
	logic                ovf_q;
	logic [PIX_W-1:0]    thr_q;
	result_t             res_q;
	logic                res_valid_q;

	logic [CNT_W-1:0]    c0_q;
	logic [SUM_W-1:0]    s0_q;
	logic [PROD_W-1:0]   a_q;
	logic [PROD_W-1:0]   b_q;
	logic [PROD_W-1:0]   diff_q;
	logic [D_W-1:0]      d_q;
	logic [N_W-1:0]      n_q;
	logic [ACC_W-1:0]    lhs_q;
	logic [N_W-1:0]      bn_q;
	logic [D_W-1:0]      bd_q;
	logic [PIX_W-1:0]    best_t_q;
	logic                have_q;

	logic [IW-1:0]       i_q;
	logic [JW-1:0]       j_q;
	logic [2*DIG_W-1:0]  pp_s1;
	logic [SH_W-1:0]     sh_s1;
	logic                ppv_s1;
	logic [ACC_W-1:0]    acc_q;

	logic                out_free;
	logic                accept;
	logic                res_load;
	logic                ram_we;
	logic [PIX_W-1:0]    ram_wa;
	logic [CNT_W-1:0]    ram_wd;
	logic [PIX_W-1:0]    ram_ra;
	logic [CNT_W-1:0]    ram_rd;
	logic [CNT_W-1:0]    c0_nx;
	logic [SUM_W-1:0]    s0_nx;
	logic [CNT_W-1:0]    c1;
	logic [XW-1:0]       x_op;
	logic [YW-1:0]       y_op;
	logic [ACC_W-1:0]    acc_add;

	otsu_ram #(
		.WIDTH (CNT_W),
		.DEPTH (BINS)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	assign out_free     = !res_valid_q || !result_stall;
	assign sample_stall = (state_q != S_IDLE) || !out_free;
	assign accept       = sample_valid && !sample_stall;
	assign res_load     = (accept && (sample.func == FUNC_BIN)) ||
	                      ((state_q == S_DONE) && out_free);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign ram_ra = (state_q == S_IDLE) ? sample.pixel : t_q;
	assign c0_nx  = c0_q + ram_rd;
	assign s0_nx  = s0_q + SUM_W'(t_q) * SUM_W'(ram_rd);
	assign c1     = cnt_q - c0_q;
	assign acc_add = ACC_W'(pp_s1) << (DIG_W * sh_s1);

	// bins are zeroed by the clear pass after reset and as the search reads them
	always_comb begin
		ram_we = 1'b0;
		ram_wa = t_q;
		ram_wd = '0;
		unique case (state_q)
			S_CLR, S_SACC: begin
				ram_we = 1'b1;
			end
			S_INC: begin
				ram_we = 1'b1;
				ram_wa = pix_q;
				ram_wd = ram_rd + CNT_W'(1);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		unique case (op_q)
			OP_A: begin
				x_op = XW'(s0_q);
				y_op = YW'(cnt_q);
			end
			OP_B: begin
				x_op = XW'(sum_q);
				y_op = YW'(c0_q);
			end
			OP_D: begin
				x_op = XW'(c0_q);
				y_op = YW'(c1);
			end
			OP_N: begin
				x_op = XW'(diff_q);
				y_op = YW'(diff_q);
			end
			OP_L: begin
				x_op = XW'(n_q);
				y_op = YW'(bd_q);
			end
			OP_R: begin
				x_op = XW'(bn_q);
				y_op = YW'(d_q);
			end
			default: begin
				x_op = '0;
				y_op = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			op_q        <= OP_A;
			t_q         <= '0;
			pix_q       <= '0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			thr_q       <= DEFAULT_THRESHOLD;
			res_q       <= '0;
			res_valid_q <= 1'b0;
			c0_q        <= '0;
			s0_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			diff_q      <= '0;
			d_q         <= '0;
			n_q         <= '0;
			lhs_q       <= '0;
			bn_q        <= '0;
			bd_q        <= '0;
			best_t_q    <= DEFAULT_THRESHOLD;
			have_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			pp_s1       <= '0;
			sh_s1       <= '0;
			ppv_s1      <= 1'b0;
			acc_q       <= '0;
		end else begin
			if (res_valid_q && !result_stall && !res_load) begin
				res_valid_q <= 1'b0;
			end

			ppv_s1 <= (state_q == S_MUL);
			if (ppv_s1) begin
				acc_q <= acc_q + acc_add;
			end

			unique case (state_q)
				S_CLR: begin
					t_q <= t_q + 8'd1;
					if (t_q == LAST_BIN) begin
						state_q <= S_IDLE;
					end
				end

				S_IDLE: begin
					if (accept) begin
						if (sample.func == FUNC_BIN) begin
							res_q.kind      <= KIND_PIXEL;
							res_q.threshold <= thr_q;
							res_q.white     <= (sample.pixel > thr_q);
							res_q.overflow  <= 1'b0;
							res_valid_q     <= 1'b1;
						end else if (cnt_q < CNT_W'(MAXP)) begin
							cnt_q   <= cnt_q + CNT_W'(1);
							sum_q   <= sum_q + SUM_W'(sample.pixel);
							pix_q   <= sample.pixel;
							last_q  <= sample.last;
							state_q <= S_INC;
						end else begin
							ovf_q <= 1'b1;
							if (sample.last) begin
								t_q      <= '0;
								c0_q     <= '0;
								s0_q     <= '0;
								have_q   <= 1'b0;
								best_t_q <= DEFAULT_THRESHOLD;
								state_q  <= S_SRD;
							end
						end
					end
				end

				S_INC: begin
					if (last_q) begin
						t_q      <= '0;
						c0_q     <= '0;
						s0_q     <= '0;
						have_q   <= 1'b0;
						best_t_q <= DEFAULT_THRESHOLD;
						state_q  <= S_SRD;
					end else begin
						state_q <= S_IDLE;
					end
				end

				S_SRD: begin
					state_q <= S_SACC;
				end

				S_SACC: begin
					c0_q <= c0_nx;
					s0_q <= s0_nx;
					if (c0_nx == '0 || c0_nx >= cnt_q) begin
						if (t_q == LAST_BIN) begin
							state_q <= S_DONE;
						end else begin
							t_q     <= t_q + 8'd1;
							state_q <= S_SRD;
						end
					end else begin
						op_q    <= OP_A;
						i_q     <= '0;
						j_q     <= '0;
						acc_q   <= '0;
						state_q <= S_MUL;
					end
				end

				// one 32x32 digit product per cycle, registered and accumulated in the next cycle
				S_MUL: begin
					pp_s1 <= x_op[DIG_W*i_q +: DIG_W] * y_op[DIG_W*j_q +: DIG_W];
					sh_s1 <= SH_W'(i_q) + SH_W'(j_q);
					if (j_q == JW'(YDIG - 1)) begin
						j_q <= '0;
						if (i_q == IW'(XDIG - 1)) begin
							state_q <= S_DRAIN;
						end else begin
							i_q <= i_q + IW'(1);
						end
					end else begin
						j_q <= j_q + JW'(1);
					end
				end

				S_DRAIN: begin
					state_q <= S_WB;
				end

				S_WB: begin
					i_q     <= '0;
					j_q     <= '0;
					acc_q   <= '0;
					state_q <= S_MUL;
					unique case (op_q)
						OP_A: begin
							a_q  <= acc_q[PROD_W-1:0];
							op_q <= OP_B;
						end
						OP_B: begin
							b_q  <= acc_q[PROD_W-1:0];
							op_q <= OP_D;
						end
						OP_D: begin
							d_q    <= acc_q[D_W-1:0];
							diff_q <= (a_q > b_q) ? a_q - b_q : b_q - a_q;
							op_q   <= OP_N;
						end
						OP_N: begin
							n_q <= acc_q[N_W-1:0];
							if (have_q) begin
								op_q <= OP_L;
							end else begin
								// first candidate with nonzero variance
								if (acc_q[N_W-1:0] != '0) begin
									have_q   <= 1'b1;
									best_t_q <= t_q;
									bn_q     <= acc_q[N_W-1:0];
									bd_q     <= d_q;
								end
								if (t_q == LAST_BIN) begin
									state_q <= S_DONE;
								end else begin
									t_q     <= t_q + 8'd1;
									state_q <= S_SRD;
								end
							end
						end
						OP_L: begin
							lhs_q <= acc_q;
							op_q  <= OP_R;
						end
						OP_R: begin
							// n/d > best_n/best_d, cross-multiplied
							if (lhs_q > acc_q) begin
								best_t_q <= t_q;
								bn_q     <= n_q;
								bd_q     <= d_q;
							end
							if (t_q == LAST_BIN) begin
								state_q <= S_DONE;
							end else begin
								t_q     <= t_q + 8'd1;
								state_q <= S_SRD;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end

				S_DONE: begin
					if (out_free) begin
						res_q.kind      <= KIND_THRESHOLD;
						res_q.threshold <= best_t_q;
						res_q.white     <= 1'b0;
						res_q.overflow  <= ovf_q;
						res_valid_q     <= 1'b1;
						thr_q           <= best_t_q;
						cnt_q           <= '0;
						sum_q           <= '0;
						ovf_q           <= 1'b0;
						t_q             <= '0;
						state_q         <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_class_split: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> ((c0_q != '0) && (c0_q < cnt_q)))
		else $error("multiplier running on a threshold with an empty class");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAXP))
		else $error("pixel count beyond frame size");

	a_pp_source: assert property (@(posedge clk) disable iff (!arst_n)
		ppv_s1 |-> ($past(state_q) == S_MUL))
		else $error("partial product valid outside multiply steps");

	a_default_thr: assert property (@(posedge clk) disable iff (!arst_n)
		!have_q |-> (best_t_q == DEFAULT_THRESHOLD))
		else $error("best threshold moved without a candidate");

	a_pixel_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.kind == KIND_PIXEL)) |-> !res_q.overflow)
		else $error("binarized pixel transfer carries overflow");
`endif

endmodule

// ===== test/otsu_result_checker.sv =====
// ----------------------------------------------------------------------------
// otsu_result_checker
// Watches both channels of the Otsu binarizer, keeps its own copy of the
// histogram and threshold, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module otsu_result_checker
	import otsu_pkg::*;
#(
	parameter int PIXEL_LIMIT = 160 * 120
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	input  logic    sample_stall,
	input  sample_t sample,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	input  logic    drain_done,
	output int      fail_count,
	output int      results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [14:0]      bin_count [BINS];
	logic [14:0]      pixels_counted;
	logic [PIX_W-1:0] threshold_now;
	logic             overflow_now;
	result_t          queued_results [$];
	int               mismatches = 0;
	int               owed_now = 0;
	bit               leftovers_checked = 1'b0;

	assign fail_count   = mismatches;
	assign results_owed = owed_now;

	task automatic note_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic expect_result(input result_t r);
		queued_results.insert(queued_results.size(), r);
	endtask

	// Exact between-class variance search; ratios compared by cross-multiplying.
	function automatic logic [PIX_W-1:0] best_split();
		bit [191:0]       total, sum_all, c0, s0, a, b, diff, num, den, best_num, best_den;
		logic [PIX_W-1:0] best;
		bit               have;
		total    = pixels_counted;
		sum_all  = '0;
		c0       = '0;
		s0       = '0;
		best_num = '0;
		best_den = '0;
		best     = DEFAULT_THRESHOLD;
		have     = 1'b0;
		for (int t = 0; t < BINS; t++)
			sum_all += t * bin_count[t];
		for (int t = 0; t < BINS; t++) begin
			c0 += bin_count[t];
			s0 += t * bin_count[t];
			if (c0 == 0 || c0 >= total)
				continue;
			a    = s0 * total;
			b    = sum_all * c0;
			diff = (a > b) ? a - b : b - a;
			num  = diff * diff;
			den  = c0 * (total - c0);
			if (!have) begin
				if (num != 0) begin
					have     = 1'b1;
					best     = PIX_W'(t);
					best_num = num;
					best_den = den;
				end
			end else if (num * best_den > best_num * den) begin
				best     = PIX_W'(t);
				best_num = num;
				best_den = den;
			end
		end
		return best;
	endfunction

	task automatic take_sample(input sample_t s);
		result_t r;
		if (s.func == FUNC_BIN) begin
			r.kind      = KIND_PIXEL;
			r.threshold = threshold_now;
			r.white     = s.pixel > threshold_now;
			r.overflow  = 1'b0;
			expect_result(r);
			return;
		end
		if (pixels_counted < PIXEL_LIMIT) begin
			bin_count[s.pixel]++;
			pixels_counted++;
		end else begin
			overflow_now = 1'b1;
		end
		if (!s.last)
			return;
		threshold_now = best_split();
		r.kind        = KIND_THRESHOLD;
		r.threshold   = threshold_now;
		r.white       = 1'b0;
		r.overflow    = overflow_now;
		expect_result(r);
		for (int i = 0; i < BINS; i++)
			bin_count[i] = '0;
		pixels_counted = '0;
		overflow_now   = 1'b0;
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (queued_results.size() == 0) begin
			note_mismatch($sformatf("unexpected result kind=%0d thr=%0d white=%0d ovf=%0d",
				got.kind, got.threshold, got.white, got.overflow));
			return;
		end
		want = queued_results.pop_front();
		if (got.kind != want.kind)
			note_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
		if (got.threshold != want.threshold)
			note_mismatch($sformatf("threshold %0d, want %0d", got.threshold, want.threshold));
		if (got.white != want.white)
			note_mismatch($sformatf("white %0d, want %0d", got.white, want.white));
		if (got.overflow != want.overflow)
			note_mismatch($sformatf("overflow %0d, want %0d", got.overflow, want.overflow));
	endtask

	// Sample side first: a result accepted on the same edge belongs to an older item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BINS; i++)
				bin_count[i] = '0;
			pixels_counted = '0;
			threshold_now  = DEFAULT_THRESHOLD;
			overflow_now   = 1'b0;
			queued_results.delete();
			owed_now <= 0;
		end else begin
			if (sample_valid && !sample_stall)
				take_sample(sample);
			if (result_valid && !result_stall)
				check_result(result);
			if (drain_done && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (queued_results.size() != 0)
					note_mismatch($sformatf("%0d results never arrived", queued_results.size()));
			end
			owed_now <= queued_results.size();
		end
	end

endmodule

// ===== test/tb_otsu_threshold_binarizer_core.sv =====
// ----------------------------------------------------------------------------
// tb_otsu_threshold_binarizer_core
// Drives histogram frames and binarize pixels into the Otsu core with random
// gaps and back-pressure; a checker beside the core predicts every result.
// ----------------------------------------------------------------------------
module tb_otsu_threshold_binarizer_core;
	timeunit 1ns;
	timeprecision 1ps;
	import otsu_pkg::*;

	localparam int IMG_W     = 160;
	localparam int IMG_H     = 120;
	localparam int PIX_LIMIT = IMG_W * IMG_H;

	logic    clk;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_stall;
	sample_t sample;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	logic    drain_done;
	int      fail_count;
	int      results_owed;

	int      sender_idle_pct = 33;
	int      recv_idle_pct   = 33;
	bit      holdoff_wanted  = 1'b0;
	int      random_items;
	bit      held_off;

	otsu_threshold_binarizer_core #(
		.IMG_WIDTH  (IMG_W),
		.IMG_HEIGHT (IMG_H)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	otsu_result_checker #(
		.PIXEL_LIMIT (PIX_LIMIT)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.drain_done   (drain_done),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#100_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int hold;
		hold         = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_wanted) begin
				holdoff_wanted = 1'b0;
				hold           = 400;
			end
			if (hold > 0) begin
				hold--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	task automatic send_sample(input logic func, input logic [PIX_W-1:0] pixel, input logic last);
		sample_t s;
		s.func  = func;
		s.pixel = pixel;
		s.last  = last;
		while ($urandom_range(99) < sender_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample       <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
	endtask

	// Stop offering and wait until every predicted result has been transferred.
	task automatic wait_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	// One histogram frame with binarize items mixed in; pixel spread varies
	// from full range down to one grey value.
	task automatic random_frame(input int len, input int bin_pct);
		int               mode, lo, span;
		logic [PIX_W-1:0] a, b, p;
		mode = $urandom_range(9);
		lo   = $urandom_range(255);
		span = $urandom_range(1, 12);
		a    = PIX_W'($urandom_range(255));
		b    = PIX_W'($urandom_range(255));
		for (int i = 0; i < len; i++) begin
			while ($urandom_range(99) < bin_pct) begin
				send_sample(FUNC_BIN, PIX_W'($urandom_range(255)), 1'($urandom_range(1)));
				random_items++;
			end
			case (mode) inside
				5, 6: p = PIX_W'((lo + $urandom_range(span)) % BINS);
				7: p = $urandom_range(1) ? a : b;
				8: p = a;
				9: p = $urandom_range(1) ? LAST_BIN : '0;
				default: p = PIX_W'($urandom_range(255));
			endcase
			send_sample(FUNC_HIST, p, i == len - 1);
			random_items++;
		end
	endtask

	initial begin
		int len;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		drain_done   = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// threshold from reset, before any frame
		send_sample(FUNC_BIN, 8'd0, 1'b0);
		send_sample(FUNC_BIN, 8'd128, 1'b0);
		send_sample(FUNC_BIN, 8'd129, 1'b1);
		send_sample(FUNC_BIN, LAST_BIN, 1'b0);
		// one grey value: no split exists, default comes back
		send_sample(FUNC_HIST, 8'd37, 1'b0);
		send_sample(FUNC_HIST, 8'd37, 1'b1);
		send_sample(FUNC_HIST, 8'd200, 1'b1);
		// extremes; binarize mid-frame uses the stored threshold
		send_sample(FUNC_HIST, 8'd0, 1'b0);
		send_sample(FUNC_BIN, 8'd200, 1'b0);
		send_sample(FUNC_HIST, LAST_BIN, 1'b1);
		send_sample(FUNC_BIN, 8'd0, 1'b0);
		send_sample(FUNC_BIN, 8'd1, 1'b1);
		send_sample(FUNC_BIN, LAST_BIN, 1'b0);
		send_sample(FUNC_HIST, 8'd10, 1'b0);
		send_sample(FUNC_HIST, 8'd10, 1'b0);
		send_sample(FUNC_HIST, 8'd200, 1'b0);
		send_sample(FUNC_HIST, 8'd201, 1'b1);
		send_sample(FUNC_BIN, LAST_BIN, 1'b1);
		send_sample(FUNC_BIN, 8'd11, 1'b0);
		wait_drained();

		send_sample(FUNC_BIN, 8'd127, 1'b0);
		send_sample(FUNC_BIN, 8'd128, 1'b0);

		random_items = 0;
		held_off     = 1'b0;
		while (random_items < 950) begin
			if (!held_off && random_items >= 300) begin
				// result side blocks; core fills and stalls its input
				held_off       = 1'b1;
				holdoff_wanted = 1'b1;
				for (int i = 0; i < 12; i++)
					send_sample(FUNC_BIN, PIX_W'($urandom_range(255)), 1'b0);
				random_items += 12;
				wait_drained();
			end
			if (random_items >= 500 && random_items < 700) begin
				sender_idle_pct = 0;
				recv_idle_pct   = 0;
			end else begin
				sender_idle_pct = 33;
				recv_idle_pct   = 33;
			end
			len = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
			random_frame(len, 30);
			if ($urandom_range(7) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (13000) @(posedge clk);
		drain_done <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
